// ===== sv/pce_pkg.sv =====
// Shared types and constants of the prefix-compressed record encoder.
package pce_pkg;

  localparam int MaxKeyBytes = 32;
  localparam int KeyAddrW    = $clog2(MaxKeyBytes);
  localparam int KeyCntW     = $clog2(MaxKeyBytes + 1);
  localparam int VarintMaxContinue = 4;

  typedef logic [2:0] part_t;
  localparam part_t PART_PFX  = 3'd0;
  localparam part_t PART_KLEN = 3'd1;
  localparam part_t PART_KEY  = 3'd2;
  localparam part_t PART_VLEN = 3'd3;
  localparam part_t PART_VAL  = 3'd4;

  localparam logic REQ_KEY = 1'b0;
  localparam logic REQ_VAL = 1'b1;

  localparam logic REG_PREFIX_EN = 1'b0;
  localparam logic REG_EPB       = 1'b1;

  localparam logic        PREFIX_EN_RST = 1'b1;
  localparam logic [15:0] EPB_RST       = 16'd16;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic [5:0]  key_len;
    logic [31:0] val_len;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    part_t      out_part;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_PFX,
    ST_KLEN,
    ST_SUF_RD,
    ST_SUF_EM,
    ST_VLEN,
    ST_VAL
  } state_t;

endpackage

// ===== sv/pce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pce_core.sv =====
// Sequencer and datapath: key store, prefix compare, header and varint emission.
module pce_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               prefix_enable,
  input  logic [15:0]        entries_per_block,
  input  logic               in_valid,
  output logic               in_ready,
  input  pce_pkg::in_item_t  in_item,
  output pce_pkg::emit_t     emit,
  input  logic               emit_take
);

  localparam logic [pce_pkg::KeyCntW-1:0] MaxFill = pce_pkg::KeyCntW'(pce_pkg::MaxKeyBytes);

  pce_pkg::state_t state_r, state_nxt;
  logic                        bank_r, bank_nxt;
  logic [pce_pkg::KeyCntW-1:0] fill_r, fill_nxt;
  logic [pce_pkg::KeyCntW-1:0] prev_len_r, prev_len_nxt;
  logic [15:0]                 cnt_r, cnt_nxt;
  logic [pce_pkg::KeyCntW-1:0] idx_r, idx_nxt;
  logic [pce_pkg::KeyCntW-1:0] common_r, common_nxt;
  logic [31:0]                 vl_r, vl_nxt;
  logic [2:0]                  vcnt_r, vcnt_nxt;

  logic                        key_wr;
  logic [7:0]                  rd0, rd1, cur_rd, prev_rd;
  logic [pce_pkg::KeyCntW-1:0] maxc, idx_inc;
  logic [15:0]                 cnt_inc;
  logic                        vcont;

  pce_ram #(.WIDTH(8), .DEPTH(pce_pkg::MaxKeyBytes)) u_bank0 (
    .clk   (clk),
    .we    (key_wr && !bank_r),
    .waddr (fill_r[pce_pkg::KeyAddrW-1:0]),
    .wdata (in_item.data_byte),
    .raddr (idx_r[pce_pkg::KeyAddrW-1:0]),
    .rdata (rd0)
  );

  pce_ram #(.WIDTH(8), .DEPTH(pce_pkg::MaxKeyBytes)) u_bank1 (
    .clk   (clk),
    .we    (key_wr && bank_r),
    .waddr (fill_r[pce_pkg::KeyAddrW-1:0]),
    .wdata (in_item.data_byte),
    .raddr (idx_r[pce_pkg::KeyAddrW-1:0]),
    .rdata (rd1)
  );

  assign cur_rd  = bank_r ? rd1 : rd0;
  assign prev_rd = bank_r ? rd0 : rd1;
  assign maxc    = (fill_r < prev_len_r) ? fill_r : prev_len_r;
  assign idx_inc = idx_r + pce_pkg::KeyCntW'(1);
  assign cnt_inc = cnt_r + 16'd1;
  assign vcont   = (vl_r[31:7] != '0) && (vcnt_r < 3'(pce_pkg::VarintMaxContinue));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pce_pkg::ST_IDLE;
      bank_r     <= 1'b0;
      fill_r     <= '0;
      prev_len_r <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      bank_r     <= bank_nxt;
      fill_r     <= fill_nxt;
      prev_len_r <= prev_len_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    common_r <= common_nxt;
    vl_r     <= vl_nxt;
    vcnt_r   <= vcnt_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    bank_nxt     = bank_r;
    fill_nxt     = fill_r;
    prev_len_nxt = prev_len_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    common_nxt   = common_r;
    vl_nxt       = vl_r;
    vcnt_nxt     = vcnt_r;
    key_wr       = 1'b0;
    in_ready     = 1'b0;
    emit         = '0;

    case (state_r)
      pce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.req_type == pce_pkg::REQ_VAL) begin
            vl_nxt    = {24'd0, in_item.data_byte};
            state_nxt = pce_pkg::ST_VAL;
          end else begin
            // drop key bytes past the store, fill saturates
            key_wr = (in_item.key_len != '0) && (fill_r < MaxFill);
            if (key_wr) begin
              fill_nxt = fill_r + pce_pkg::KeyCntW'(1);
            end
            if (in_item.key_len == '0 || in_item.last_byte) begin
              vl_nxt     = in_item.val_len;
              vcnt_nxt   = '0;
              idx_nxt    = '0;
              common_nxt = '0;
              state_nxt  = prefix_enable ? pce_pkg::ST_CMP_RD : pce_pkg::ST_KLEN;
            end
          end
        end
      end
      pce_pkg::ST_CMP_RD: begin
        if (idx_r >= maxc) begin
          common_nxt = idx_r;
          state_nxt  = pce_pkg::ST_PFX;
        end else begin
          state_nxt = pce_pkg::ST_CMP_CHK;
        end
      end
      pce_pkg::ST_CMP_CHK: begin
        if (cur_rd == prev_rd) begin
          idx_nxt   = idx_inc;
          state_nxt = pce_pkg::ST_CMP_RD;
        end else begin
          common_nxt = idx_r;
          state_nxt  = pce_pkg::ST_PFX;
        end
      end
      pce_pkg::ST_PFX: begin
        emit.valid = 1'b1;
        emit.item  = '{out_byte: 8'(common_r), out_part: pce_pkg::PART_PFX, last_of_run: 1'b0};
        if (emit_take) begin
          state_nxt = pce_pkg::ST_KLEN;
        end
      end
      pce_pkg::ST_KLEN: begin
        emit.valid = 1'b1;
        emit.item  = '{out_byte: 8'(fill_r - common_r), out_part: pce_pkg::PART_KLEN,
                       last_of_run: 1'b0};
        if (emit_take) begin
          idx_nxt   = common_r;
          state_nxt = (common_r < fill_r) ? pce_pkg::ST_SUF_RD : pce_pkg::ST_VLEN;
        end
      end
      pce_pkg::ST_SUF_RD: begin
        state_nxt = pce_pkg::ST_SUF_EM;
      end
      pce_pkg::ST_SUF_EM: begin
        emit.valid = 1'b1;
        emit.item  = '{out_byte: cur_rd, out_part: pce_pkg::PART_KEY, last_of_run: 1'b0};
        if (emit_take) begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc < fill_r) ? pce_pkg::ST_SUF_RD : pce_pkg::ST_VLEN;
        end
      end
      pce_pkg::ST_VLEN: begin
        emit.valid = 1'b1;
        emit.item  = '{out_byte: {vcont, vl_r[6:0]}, out_part: pce_pkg::PART_VLEN,
                       last_of_run: !vcont};
        if (emit_take) begin
          if (vcont) begin
            vl_nxt   = vl_r >> 7;
            vcnt_nxt = vcnt_r + 3'd1;
          end else begin
            // retire the record: current key becomes the previous key
            bank_nxt = !bank_r;
            fill_nxt = '0;
            if (cnt_inc >= entries_per_block) begin
              cnt_nxt      = '0;
              prev_len_nxt = '0;
            end else begin
              cnt_nxt      = cnt_inc;
              prev_len_nxt = fill_r;
            end
            state_nxt = pce_pkg::ST_IDLE;
          end
        end
      end
      pce_pkg::ST_VAL: begin
        emit.valid = 1'b1;
        emit.item  = '{out_byte: vl_r[7:0], out_part: pce_pkg::PART_VAL, last_of_run: 1'b1};
        if (emit_take) begin
          state_nxt = pce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/prefix_compressed_record_encoder.sv =====
// Top level: configuration registers, sequencer core and output register.
//
// Records arrive on the in_ channel one byte per beat: key bytes (req_type 0)
// with key_len and val_len, then value bytes (req_type 1). Encoded
// bytes leave on the out_ channel, tagged with out_part; last_of_run marks
// the final beat caused by one input beat. The APB port (psel ... pready)
// holds prefix_enable at address 0 and entries_per_block at address 4.
// Steps per input beat, set by the sequencer walking the two key banks:
//   key byte that does not end the key: accepted, in_ready stays high.
//   value byte: accepted, then loaded into the output register.
//   key end in prefix mode: compare the C common-prefix bytes (plus one
//   differing byte when one ends the compare), then emit the prefix byte,
//   the key-length byte, the S suffix bytes and the V varint bytes, 1..5;
//   raw mode drops the compare and the prefix byte and emits all K key bytes.
// Each result is loaded into the output register from the state that produces it.
// Reset clears the sequencer, the output register, the previous key length,
// the record count, and loads the register defaults; no clearing pass runs.
// A stalled receiver (out_ready low) holds out_valid and out_item, and the
// sequencer waits with it; in_ready stays low until the run is done.
module prefix_compressed_record_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pce_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pce_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic               prefix_en_r;
  logic [15:0]        epb_r;
  logic               out_valid_r;
  pce_pkg::out_item_t out_item_r;
  pce_pkg::emit_t     emit;
  logic               emit_take;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_en_r <= pce_pkg::PREFIX_EN_RST;
      epb_r       <= pce_pkg::EPB_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        pce_pkg::REG_PREFIX_EN: prefix_en_r <= pwdata[0];
        pce_pkg::REG_EPB:       epb_r       <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pce_pkg::REG_PREFIX_EN: prdata = {31'd0, prefix_en_r};
      pce_pkg::REG_EPB:       prdata = {16'd0, epb_r};
      default:                prdata = '0;
    endcase
  end

  pce_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .prefix_enable     (prefix_en_r),
    .entries_per_block (epb_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_item           (in_item),
    .emit              (emit),
    .emit_take         (emit_take)
  );

  // load a new beat when the register is empty or its beat is leaving
  assign emit_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_take) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take && emit.valid) begin
      out_item_r <= emit.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/pce_checker.sv =====
// Port-level checker for the record encoder, bound to the top level.
module pce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pce_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input pce_pkg::out_item_t out_item
);

  logic in_beat, ends_run;

  assign in_beat  = in_valid && in_ready;
  assign ends_run = (in_item.req_type == pce_pkg::REQ_VAL) || in_item.last_byte ||
                    (in_item.key_len == '0);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled output beat changed");

  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && ends_run |=> !in_ready)
    else $error("ready high while a run is being emitted");

  a_key_stream: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !ends_run |=> in_ready)
    else $error("ready dropped on a mid-key byte");

  a_value_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.out_part == pce_pkg::PART_VAL) |-> out_item.last_of_run)
    else $error("value byte not marked last of run");

endmodule

bind prefix_compressed_record_encoder pce_checker u_pce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== test/prefix_compressed_record_encoder_tb.sv =====
// Self-checking testbench for the prefix-compressed record encoder.
module prefix_compressed_record_encoder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 55;
  localparam int SettleCycles = 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  pce_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pce_pkg::out_item_t out_item;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  prefix_compressed_record_encoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Encoder state as seen by the predictor.
  logic [7:0]  prev_key [pce_pkg::MaxKeyBytes];
  logic [7:0]  cur_key [pce_pkg::MaxKeyBytes];
  int          prev_len;
  int          cur_fill;
  logic [15:0] record_count;
  logic        prefix_en;
  logic [15:0] recs_per_block;

  pce_pkg::in_item_t  pending_beats [$];
  pce_pkg::out_item_t expected_bytes [$];
  logic [7:0]  rec_key [$];
  logic [7:0]  last_gen_key [$];
  int          queued_items = 0;
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          ready_tick = 0;

  task automatic report(input string field, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] b, input pce_pkg::part_t p);
    expected_bytes.push_back(pce_pkg::out_item_t'{out_byte: b, out_part: p, last_of_run: 1'b0});
  endtask

  task automatic push_varint(input logic [31:0] v, input pce_pkg::part_t p);
    while (v >= 32'd128) begin
      push_byte({1'b1, v[6:0]}, p);
      v = v >> 7;
    end
    push_byte(v[7:0], p);
  endtask

  task automatic predict_encoding(input pce_pkg::in_item_t it);
    int common;
    int klen;
    int maxc;
    int i;
    if (it.req_type == pce_pkg::REQ_VAL) begin
      expected_bytes.push_back(pce_pkg::out_item_t'{out_byte: it.data_byte,
                                                    out_part: pce_pkg::PART_VAL,
                                                    last_of_run: 1'b1});
      return;
    end
    if (it.key_len != 6'd0) begin
      // saturate: bytes past the key store are dropped
      if (cur_fill < pce_pkg::MaxKeyBytes) begin
        cur_key[cur_fill] = it.data_byte;
        cur_fill++;
      end
      if (!it.last_byte) return;
    end
    klen = cur_fill;
    common = 0;
    if (prefix_en) begin
      maxc = (klen < prev_len) ? klen : prev_len;
      while (common < maxc && cur_key[common] == prev_key[common]) common++;
      push_varint(common, pce_pkg::PART_PFX);
    end
    push_varint(klen - common, pce_pkg::PART_KLEN);
    for (i = common; i < klen; i++) push_byte(cur_key[i], pce_pkg::PART_KEY);
    push_varint(it.val_len, pce_pkg::PART_VLEN);
    expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
    for (i = 0; i < klen; i++) prev_key[i] = cur_key[i];
    prev_len = klen;
    cur_fill = 0;
    record_count = record_count + 16'd1;
    if (record_count >= recs_per_block) begin
      record_count = '0;
      prev_len = 0;
    end
  endtask

  task automatic push_value(input logic [7:0] data, input logic last);
    pce_pkg::in_item_t it;
    it = '0;
    it.req_type = pce_pkg::REQ_VAL;
    it.data_byte = data;
    it.key_len = 6'($urandom_range(0, 32));
    it.val_len = $urandom;
    it.last_byte = last;
    pending_beats.push_back(it);
    queued_items++;
  endtask

  // Queue the key in rec_key, ended by its last byte or by an empty-key beat,
  // followed by nval value bytes.
  task automatic add_record(input bit end_empty, input logic [5:0] klen_field,
                            input logic [31:0] vlen, input int nval);
    pce_pkg::in_item_t it;
    int n;
    int i;
    n = rec_key.size();
    for (i = 0; i < n; i++) begin
      it = '0;
      it.req_type = pce_pkg::REQ_KEY;
      it.data_byte = rec_key[i];
      it.key_len = klen_field;
      it.val_len = vlen;
      it.last_byte = !end_empty && (i == n - 1);
      pending_beats.push_back(it);
      queued_items++;
    end
    if (end_empty || n == 0) begin
      it = '0;
      it.req_type = pce_pkg::REQ_KEY;
      it.data_byte = 8'($urandom);
      it.key_len = 6'd0;
      it.val_len = vlen;
      it.last_byte = 1'($urandom_range(0, 1));
      pending_beats.push_back(it);
      queued_items++;
    end
    for (i = 0; i < nval; i++) push_value(8'($urandom), i == nval - 1);
    last_gen_key = rec_key;
  endtask

  task automatic random_record();
    int ksz;
    int sel;
    int pfx;
    int i;
    bit narrow;
    bit end_empty;
    logic [5:0] kfield;
    logic [31:0] vlen;
    sel = $urandom_range(0, 99);
    if (sel < 10) ksz = 0;
    else if (sel < 80) ksz = $urandom_range(1, 8);
    else if (sel < 95) ksz = $urandom_range(9, 32);
    else ksz = $urandom_range(33, 40);
    rec_key.delete();
    // share a prefix with the last key most of the time
    if ($urandom_range(0, 9) < 6) begin
      pfx = (ksz < last_gen_key.size()) ? ksz : last_gen_key.size();
      pfx = $urandom_range(0, pfx);
      for (i = 0; i < pfx; i++) rec_key.push_back(last_gen_key[i]);
    end
    narrow = 1'($urandom_range(0, 1));
    while (rec_key.size() < ksz)
      rec_key.push_back(narrow ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom_range(0, 255)));
    end_empty = (ksz == 0) || ($urandom_range(0, 9) == 0);
    if (ksz == 0 || ksz > 32 || $urandom_range(0, 4) == 0) kfield = 6'($urandom_range(1, 32));
    else kfield = 6'(ksz);
    sel = $urandom_range(0, 19);
    if (sel < 10) vlen = $urandom_range(0, 127);
    else if (sel < 15) vlen = $urandom_range(128, 16383);
    else if (sel < 18) vlen = $urandom_range(16384, 32'h001F_FFFF);
    else vlen = $urandom;
    if ($urandom_range(0, 19) == 0) push_value(8'($urandom), 1'($urandom_range(0, 1)));
    add_record(end_empty, kfield, vlen, $urandom_range(0, 3));
  endtask

  // Hold until the sender is empty and every expected byte has arrived.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == pce_pkg::REG_PREFIX_EN) prefix_en = data[0];
    else recs_per_block = data[15:0];
  endtask

  task automatic run_phase(input logic pen, input logic [15:0] epb);
    int start;
    apb_write(pce_pkg::REG_PREFIX_EN, {31'd0, pen});
    apb_write(pce_pkg::REG_EPB, {16'd0, epb});
    start = queued_items;
    while (queued_items - start < PhaseItems) random_record();
    wait_idle();
  endtask

  // Driver: bursts of beats with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && in_ready) predict_encoding(in_item);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_item <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each beat with the oldest expected byte; stall on a rotating pattern.
  always @(posedge clk) begin
    pce_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected beat", out_item.out_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report("out_byte", out_item.out_byte, want.out_byte);
          if (out_item.out_part !== want.out_part)
            report("out_part", out_item.out_part, want.out_part);
          if (out_item.last_of_run !== want.last_of_run)
            report("last_of_run", out_item.last_of_run, want.last_of_run);
        end
      end
      ready_tick++;
      case ((ready_tick / 150) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((ready_tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    prev_len = 0;
    cur_fill = 0;
    record_count = '0;
    prefix_en = pce_pkg::PREFIX_EN_RST;
    recs_per_block = pce_pkg::EPB_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset configuration.
    push_value(8'h00, 1'b0);
    rec_key = '{8'h41};
    add_record(1'b0, 6'd1, 32'd0, 0);
    push_value(8'hFF, 1'b1);
    rec_key = '{8'h41, 8'h42};
    add_record(1'b0, 6'd2, 32'd127, 0);
    rec_key.delete();
    add_record(1'b1, 6'd1, 32'd128, 0);
    // key bytes closed by an empty-key beat
    rec_key = '{8'h41, 8'h42};
    add_record(1'b1, 6'd2, 32'hFFFF_FFFF, 0);
    // identical key: empty suffix
    rec_key = '{8'h41, 8'h42};
    add_record(1'b0, 6'd2, 32'd16383, 0);
    // key length field disagrees with the byte count
    rec_key = '{8'h00, 8'hFF, 8'h80};
    add_record(1'b0, 6'd32, 32'd16384, 1);
    wait_idle();

    run_phase(1'b1, 16'd1);
    run_phase(1'b0, 16'd65535);
    run_phase(1'b1, 16'd3);
    run_phase(1'b0, 16'd2);
    run_phase(1'b1, 16'd0);
    run_phase(1'b1, 16'd65535);
    run_phase(1'b1, 16'd16);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
